[design/cgmh_pkg.sv]
// Shared types, codes and defaults for the chaos-game midpoint histogram.
package cgmh_pkg;

  // Default sizes handed to the top level as parameter defaults.
  localparam int GridSizeDefault   = 256;
  localparam int StackDepthDefault = 32;
  localparam int MaxCornersDefault = 6;

  // Field widths fixed by the interface.
  localparam int CornerW   = 8;
  localparam int CoordW    = 8;
  localparam int StatusW   = 2;
  localparam int CountW    = 32;
  localparam int PointW    = 32;
  localparam int HalfW     = 16;
  localparam int FracW     = 7;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int CornerCntW = 3;
  localparam int MaxDepthW  = 5;

  // Depth of the result buffer in front of the output port.
  localparam int OutFifoDepth = 3;

  // Corner code that pops the path stack.
  localparam logic [CornerW-1:0] PopCode = 8'hFF;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk         = 2'd0;
  localparam logic [StatusW-1:0] StBadCorner  = 2'd1;
  localparam logic [StatusW-1:0] StPopRefused = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgCornerCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxDepth    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCornerFirst = 3'd2;

  // Reset values of the configuration registers.
  localparam logic [CornerCntW-1:0] CornerCountReset = 3'd3;
  localparam logic [MaxDepthW-1:0]  MaxDepthReset    = 5'd8;

  // Stack update request from the decode stage.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PointW-1:0] data;
  } stk_req_t;

  // Histogram request that travels with the bin index.
  typedef struct packed {
    logic               valid;
    logic               rd;
    logic               inc;
    logic [StatusW-1:0] status;
  } hist_req_t;

  // Histogram pipeline status seen by the input flow control.
  typedef struct packed {
    logic busy;
    logic s1_valid;
  } hist_stat_t;

  // One result item.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
  } res_t;

endpackage

[design/chaos_game_midpoint_histogram.sv]
// Chaos-game midpoint histogram: one item per cycle unless stalled, one result per item.
// Each result passes the histogram's second stage and the result buffer to the output.
// The item rate rests on the histogram read-modify-write with forwarding.
// After reset a clearing pass zeroes the histogram, one bin per cycle, over all
// GridSize*GridSize bins (65536 by default); in_stall_o stays high until it ends.
// Configuration writes are taken at any time, also during the clearing pass.
module chaos_game_midpoint_histogram #(
  parameter int GridSize   = cgmh_pkg::GridSizeDefault,
  parameter int StackDepth = cgmh_pkg::StackDepthDefault,
  parameter int MaxCorners = cgmh_pkg::MaxCornersDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [cgmh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cgmh_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [cgmh_pkg::CornerW-1:0]   corner_i,
  input  logic [cgmh_pkg::CoordW-1:0]    read_x_i,
  input  logic [cgmh_pkg::CoordW-1:0]    read_y_i,
  // Output channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [cgmh_pkg::StatusW-1:0]   status_o,
  output logic [cgmh_pkg::CountW-1:0]    bin_count_o
);
  import cgmh_pkg::*;

  localparam int LvlW    = $clog2(StackDepth + 1);
  localparam int IdxW    = $clog2(GridSize * GridSize);
  localparam int CornerW_ = (MaxCorners > 1) ? $clog2(MaxCorners) : 1;
  localparam int BinW    = HalfW - FracW;
  localparam int FCntW   = $clog2(OutFifoDepth + 1);

  // Configuration registers.
  logic [CornerCntW-1:0] corner_count_q;
  logic [MaxDepthW-1:0]  max_depth_q;
  logic [PointW-1:0]     corner_q [MaxCorners];

  logic [CfgIdxW-1:0]    corner_wsel;

  assign corner_wsel = cfg_idx_i - CfgCornerFirst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_count_q <= CornerCountReset;
      max_depth_q    <= MaxDepthReset;
      for (int i = 0; i < MaxCorners; i++) begin
        corner_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgCornerCount) begin
        corner_count_q <= cfg_wdata_i[CornerCntW-1:0];
      end else if (cfg_idx_i == CfgMaxDepth) begin
        max_depth_q <= cfg_wdata_i[MaxDepthW-1:0];
      end else begin
        for (int i = 0; i < MaxCorners; i++) begin
          if (32'(corner_wsel) == i) begin
            corner_q[i] <= cfg_wdata_i;
          end
        end
      end
    end
  end

  // Submodule connections.
  stk_req_t          stk_req;
  logic [PointW-1:0] top_pt;
  logic [LvlW-1:0]   level;
  hist_req_t         hist_req;
  logic [IdxW-1:0]   hist_idx;
  logic              res_valid;
  res_t              res;
  hist_stat_t        hist_stat;
  logic [FCntW-1:0]  fifo_cnt;
  res_t              out_res;

  // Decode signals.
  logic                accept;
  logic                is_pop;
  logic                corner_ok;
  logic [CornerW_-1:0] corner_sel;
  logic [PointW-1:0]   corner_pt;
  logic [HalfW-1:0]    mid_x;
  logic [HalfW-1:0]    mid_y;
  logic [BinW-1:0]     bin_x;
  logic [BinW-1:0]     bin_y;
  logic                mid_on_grid;
  logic                rd_on_grid;
  logic [IdxW-1:0]     mid_idx;
  logic [IdxW-1:0]     rd_idx;
  logic                can_push;
  logic [StatusW-1:0]  status;

  // Flow control: room is kept for the item in the second stage and the new one.
  assign in_stall_o = hist_stat.busy ||
                      ((32'(fifo_cnt) + 32'(hist_stat.s1_valid)) > (OutFifoDepth - 1));
  assign accept     = in_valid_i && !in_stall_o;

  // Corner check and selection.
  assign is_pop     = (corner_i == PopCode);
  assign corner_ok  = (32'(corner_i) < 32'(corner_count_q)) && (32'(corner_i) < MaxCorners);
  assign corner_sel = corner_ok ? corner_i[CornerW_-1:0] : '0;
  assign corner_pt  = corner_q[corner_sel];

  // Midpoint per coordinate, truncating the half LSB.
  assign mid_x = HalfW'((17'(top_pt[HalfW-1:0]) + 17'(corner_pt[HalfW-1:0])) >> 1);
  assign mid_y = HalfW'((17'(top_pt[PointW-1:HalfW]) + 17'(corner_pt[PointW-1:HalfW])) >> 1);
  assign bin_x = mid_x[HalfW-1:FracW];
  assign bin_y = mid_y[HalfW-1:FracW];

  // Bin indexes for the step and the read.
  assign mid_on_grid = (32'(bin_x) < GridSize) && (32'(bin_y) < GridSize);
  assign rd_on_grid  = (32'(read_x_i) < GridSize) && (32'(read_y_i) < GridSize);
  assign mid_idx     = IdxW'(32'(bin_x) * GridSize + 32'(bin_y));
  assign rd_idx      = IdxW'(32'(read_x_i) * GridSize + 32'(read_y_i));

  // Push rule: below max_depth+1 and below the stack depth.
  assign can_push = (32'(level) <= 32'(max_depth_q)) && (32'(level) < StackDepth);

  // Result status.
  always_comb begin
    priority if (kind_i) begin
      status = StOk;
    end else if (is_pop) begin
      status = (level <= LvlW'(1)) ? StPopRefused : StOk;
    end else if (!corner_ok) begin
      status = StBadCorner;
    end else begin
      status = StOk;
    end
  end

  // Requests to the stack and the histogram.
  always_comb begin
    stk_req.pop  = accept && !kind_i && is_pop && (level > LvlW'(1));
    stk_req.push = accept && !kind_i && !is_pop && corner_ok && can_push;
    stk_req.data = {mid_y, mid_x};

    hist_req.valid  = accept;
    hist_req.rd     = kind_i && rd_on_grid;
    hist_req.inc    = !kind_i && !is_pop && corner_ok && mid_on_grid;
    hist_req.status = status;
    hist_idx        = kind_i ? rd_idx : mid_idx;
  end

  cgmh_path_stack #(
    .StackDepth(StackDepth),
    .LvlW      (LvlW)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stk_req),
    .top_o  (top_pt),
    .level_o(level)
  );

  cgmh_hist #(
    .GridSize(GridSize),
    .IdxW    (IdxW)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (hist_req),
    .idx_i      (hist_idx),
    .res_valid_o(res_valid),
    .res_o      (res),
    .stat_o     (hist_stat)
  );

  cgmh_out_fifo #(
    .Depth(OutFifoDepth),
    .CntW (FCntW)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop_i      (!out_stall_i),
    .valid_o    (out_valid_o),
    .data_o     (out_res),
    .count_o    (fifo_cnt)
  );

  assign status_o    = out_res.status;
  assign bin_count_o = out_res.count;

endmodule

[design/cgmh_path_stack.sv]
// Path stack: top-of-stack register, level counter and a prefetched entry below the top.
module cgmh_path_stack #(
  parameter int StackDepth = cgmh_pkg::StackDepthDefault,
  parameter int LvlW       = $clog2(StackDepth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cgmh_pkg::stk_req_t         req_i,
  output logic [cgmh_pkg::PointW-1:0] top_o,
  output logic [LvlW-1:0]            level_o
);
  import cgmh_pkg::*;

  localparam int SlotW = $clog2(StackDepth);

  logic [PointW-1:0] stack_mem [StackDepth];
  logic [PointW-1:0] top_q, top_d;
  logic [LvlW-1:0]   level_q, level_d;
  logic [PointW-1:0] below_q;
  logic              below_origin_q;
  logic [PointW-1:0] below;
  logic [SlotW-1:0]  rd_addr;

  // Entry 0 is the origin and is never stored in the memory.
  assign below = below_origin_q ? '0 : below_q;

  // Next level and top of stack.
  always_comb begin
    level_d = level_q;
    top_d   = top_q;
    if (req_i.push) begin
      level_d = level_q + LvlW'(1);
      top_d   = req_i.data;
    end else if (req_i.pop) begin
      level_d = level_q - LvlW'(1);
      top_d   = below;
    end
  end

  // The prefetch reads the entry just below the next top; it never equals the
  // entry written in the same cycle.
  assign rd_addr = SlotW'(level_d - LvlW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q        <= LvlW'(1);
      top_q          <= '0;
      below_origin_q <= 1'b0;
    end else begin
      level_q        <= level_d;
      top_q          <= top_d;
      below_origin_q <= (level_d == LvlW'(2));
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      stack_mem[level_q[SlotW-1:0]] <= req_i.data;
    end
    below_q <= stack_mem[rd_addr];
  end

  assign top_o   = top_q;
  assign level_o = level_q;

`ifndef SYNTH
  // The level stays between the origin and the stack depth.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q >= LvlW'(1)) && (32'(level_q) <= StackDepth))
    else $error("stack level out of range");

  // Pushes only go to a free slot and pops never remove the origin.
  a_req_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.push && req_i.pop) && (!req_i.push || 32'(level_q) < StackDepth)
    && (!req_i.pop || level_q > LvlW'(1)))
    else $error("illegal stack request");
`endif

endmodule

[design/cgmh_hist.sv]
// Histogram memory with clearing pass and a read-modify-write pipeline with forwarding.
module cgmh_hist #(
  parameter int GridSize = cgmh_pkg::GridSizeDefault,
  parameter int IdxW     = $clog2(GridSize * GridSize)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cgmh_pkg::hist_req_t  req_i,
  input  logic [IdxW-1:0]      idx_i,
  output logic                 res_valid_o,
  output cgmh_pkg::res_t       res_o,
  output cgmh_pkg::hist_stat_t stat_o
);
  import cgmh_pkg::*;

  localparam int Depth = GridSize * GridSize;

  logic [CountW-1:0]  hist_mem [Depth];
  logic [CountW-1:0]  rdata_q;

  // Clearing pass state.
  logic               clr_q;
  logic [IdxW-1:0]    clr_cnt_q;

  // Second stage: data from the memory arrives here.
  logic               s1_valid_q;
  logic               s1_rd_q;
  logic               s1_inc_q;
  logic [StatusW-1:0] s1_status_q;
  logic [IdxW-1:0]    s1_idx_q;

  // Last write, forwarded to a read issued in the same cycle as that write.
  logic               fw_valid_q;
  logic [IdxW-1:0]    fw_idx_q;
  logic [CountW-1:0]  fw_data_q;

  logic [CountW-1:0]  cur_count;
  logic [CountW-1:0]  new_count;
  logic               s1_we;
  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr;
  logic [CountW-1:0]  mem_wdata;

  // Current bin value with forwarding from the write just retired.
  assign cur_count = (fw_valid_q && (fw_idx_q == s1_idx_q)) ? fw_data_q : rdata_q;
  assign new_count = cur_count + CountW'(1);
  assign s1_we     = s1_valid_q && s1_inc_q;

  // The clearing pass owns the write port until it is done.
  assign mem_we    = clr_q || s1_we;
  assign mem_waddr = clr_q ? clr_cnt_q : s1_idx_q;
  assign mem_wdata = clr_q ? '0 : new_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      fw_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
        if (clr_cnt_q == IdxW'(Depth - 1)) begin
          clr_q <= 1'b0;
        end
      end
      s1_valid_q <= req_i.valid;
      fw_valid_q <= s1_we;
    end
  end

  // Stage payload and forwarding data.
  always_ff @(posedge clk_i) begin
    s1_rd_q     <= req_i.rd;
    s1_inc_q    <= req_i.inc;
    s1_status_q <= req_i.status;
    s1_idx_q    <= idx_i;
    fw_idx_q    <= s1_idx_q;
    fw_data_q   <= new_count;
  end

  // Histogram memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= hist_mem[idx_i];
  end

  // Result of the item in the second stage.
  always_comb begin
    res_o.status = s1_status_q;
    if (s1_rd_q) begin
      res_o.count = cur_count;
    end else if (s1_inc_q) begin
      res_o.count = new_count;
    end else begin
      res_o.count = '0;
    end
  end

  assign res_valid_o     = s1_valid_q;
  assign stat_o.busy     = clr_q;
  assign stat_o.s1_valid = s1_valid_q;

`ifndef SYNTH
  // No item enters while the clearing pass runs.
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> !clr_q)
    else $error("histogram request during clearing pass");
`endif

endmodule

[design/cgmh_out_fifo.sv]
// Small result buffer that decouples the histogram pipeline from the output port.
module cgmh_out_fifo #(
  parameter int Depth = cgmh_pkg::OutFifoDepth,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cgmh_pkg::res_t push_data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output cgmh_pkg::res_t data_o,
  output logic [CntW-1:0] count_o
);
  import cgmh_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  res_t            ent_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // Pointers wrap at the buffer depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_ptr_q];
  assign count_o = cnt_q;

`ifndef SYNTH
  // The input flow control must leave room for every result in flight.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (32'(cnt_q) < Depth))
    else $error("result buffer overflow");
`endif

endmodule

[bench/cgmh_hist_checker.sv]
// Checker for the chaos-game histogram: tracks stack and bins, checks every result transfer.
module cgmh_hist_checker #(
  parameter int GridSize   = cgmh_pkg::GridSizeDefault,
  parameter int StackDepth = cgmh_pkg::StackDepthDefault,
  parameter int MaxCorners = cgmh_pkg::MaxCornersDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cgmh_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cgmh_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          kind_i,
  input  logic [cgmh_pkg::CornerW-1:0]  corner_i,
  input  logic [cgmh_pkg::CoordW-1:0]   read_x_i,
  input  logic [cgmh_pkg::CoordW-1:0]   read_y_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [cgmh_pkg::StatusW-1:0]  status_i,
  input  logic [cgmh_pkg::CountW-1:0]   bin_count_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import cgmh_pkg::*;

  // Shadow of the block's state and configuration.
  logic [PointW-1:0]     path_pts [StackDepth];
  int unsigned           level;
  logic [CountW-1:0]     hits [GridSize*GridSize];
  logic [CornerCntW-1:0] n_corners;
  logic [MaxDepthW-1:0]  depth_cap;
  logic [PointW-1:0]     corner_pts [MaxCorners];

  // Results still owed by the block, oldest first.
  res_t expected_bins [$];
  res_t want;
  int   result_idx;

  // Applies one accepted item to the shadow state and returns its result.
  function automatic res_t step_histogram(input logic kind, input logic [CornerW-1:0] corner,
                                          input logic [CoordW-1:0] rx,
                                          input logic [CoordW-1:0] ry);
    res_t              r;
    logic [PointW-1:0] top_pt;
    logic [PointW-1:0] cpt;
    logic [HalfW:0]    sum_x;
    logic [HalfW:0]    sum_y;
    logic [HalfW-1:0]  mid_x;
    logic [HalfW-1:0]  mid_y;
    int unsigned       bx;
    int unsigned       by;
    int unsigned       push_limit;
    r.status = StOk;
    r.count  = '0;
    if (kind) begin
      if (rx < GridSize && ry < GridSize) r.count = hits[rx * GridSize + ry];
    end else if (corner == PopCode) begin
      if (level <= 1) r.status = StPopRefused;
      else level--;
    end else if (corner >= n_corners || corner >= MaxCorners) begin
      r.status = StBadCorner;
    end else begin
      // Midpoint per coordinate, half LSB dropped; the bin is the integer part.
      top_pt = path_pts[level - 1];
      cpt    = corner_pts[corner];
      sum_x  = {1'b0, top_pt[HalfW-1:0]} + {1'b0, cpt[HalfW-1:0]};
      sum_y  = {1'b0, top_pt[PointW-1:HalfW]} + {1'b0, cpt[PointW-1:HalfW]};
      mid_x  = sum_x[HalfW:1];
      mid_y  = sum_y[HalfW:1];
      bx     = mid_x >> FracW;
      by     = mid_y >> FracW;
      if (bx < GridSize && by < GridSize) begin
        hits[bx * GridSize + by] = hits[bx * GridSize + by] + 1'b1;
        r.count = hits[bx * GridSize + by];
      end
      // Push while the stack is below both the configured depth and its size.
      push_limit = depth_cap + 1;
      if (push_limit > StackDepth) push_limit = StackDepth;
      if (level < push_limit) begin
        path_pts[level] = {mid_y, mid_x};
        level++;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GridSize*GridSize; i++) hits[i] = '0;
      for (int i = 0; i < StackDepth; i++) path_pts[i] = '0;
      for (int i = 0; i < MaxCorners; i++) corner_pts[i] = '0;
      level        = 1;
      n_corners    = CornerCountReset;
      depth_cap    = MaxDepthReset;
      result_idx   = 0;
      fail_count_o = 0;
      expected_bins.delete();
    end else begin
      // Check a result transfer against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (expected_bins.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("mismatch: unexpected result status %0d bin_count %0d",
                     status_i, bin_count_i);
        end else begin
          want = expected_bins.pop_front();
          if (status_i !== want.status || bin_count_i !== want.count) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"mismatch at result %0d: status exp %0d got %0d, ",
                        "bin_count exp %0d got %0d"},
                       result_idx, want.status, status_i, want.count, bin_count_i);
          end
        end
        result_idx++;
      end
      // Predict the result of an input transfer.
      if (in_valid_i && !in_stall_i)
        expected_bins.push_back(step_histogram(kind_i, corner_i, read_x_i, read_y_i));
      // Track register writes; only the low bits of the narrow registers count.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCornerCount: n_corners = cfg_wdata_i[CornerCntW-1:0];
          CfgMaxDepth:    depth_cap = cfg_wdata_i[MaxDepthW-1:0];
          default: begin
            if (cfg_idx_i >= CfgCornerFirst && cfg_idx_i - CfgCornerFirst < MaxCorners)
              corner_pts[cfg_idx_i - CfgCornerFirst] = cfg_wdata_i;
          end
        endcase
      end
    end
    pending_o = expected_bins.size();
  end

endmodule

[bench/tb_chaos_game_midpoint_histogram.sv]
// Testbench top for the chaos-game histogram: clock, reset, stimulus, watchdog and verdict.
module tb_chaos_game_midpoint_histogram;
  import cgmh_pkg::*;

  localparam int NumPhases     = 12;
  localparam int ItemsPerPhase = 155;
  localparam int ReadPct       = 20;
  localparam int NoisePct      = 4;
  // Covers the clearing pass after reset several times over.
  localparam int QuietLimit    = 300000;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                kind_i       = 1'b0;
  logic [CornerW-1:0]  corner_i     = '0;
  logic [CoordW-1:0]   read_x_i     = '0;
  logic [CoordW-1:0]   read_y_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [CountW-1:0]   bin_count_o;

  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned out_stall_pct = 0;

  // Per-phase stimulus knobs.
  logic [PointW-1:0] corner_set [MaxCornersDefault];
  logic [31:0]       rnd_word;
  int unsigned       n_sel;
  int unsigned       n_use;
  int unsigned       depth_sel;
  int unsigned       span;
  int unsigned       reach;
  int unsigned       pop_pct;
  int unsigned       pick;

  chaos_game_midpoint_histogram dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .corner_i    (corner_i),
    .read_x_i    (read_x_i),
    .read_y_i    (read_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .bin_count_o (bin_count_o)
  );

  cgmh_hist_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .kind_i       (kind_i),
    .corner_i     (corner_i),
    .read_x_i     (read_x_i),
    .read_y_i     (read_y_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .bin_count_i  (bin_count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: random stall at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer, preceded by random idle cycles.
  task automatic send_item(input logic kind, input logic [CornerW-1:0] corner,
                           input logic [CoordW-1:0] rx, input logic [CoordW-1:0] ry);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    corner_i   <= corner;
    read_x_i   <= rx;
    read_y_i   <= ry;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes every register: corner count, depth, then the corner points.
  task automatic load_config(input logic [31:0] count_word, input logic [31:0] depth_word);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgCornerCount;
    cfg_wdata_i <= count_word;
    @(posedge clk_i);
    cfg_idx_i   <= CfgMaxDepth;
    cfg_wdata_i <= depth_word;
    @(posedge clk_i);
    for (int i = 0; i < MaxCornersDefault; i++) begin
      cfg_idx_i   <= CfgCornerFirst + i[CfgIdxW-1:0];
      cfg_wdata_i <= corner_set[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme corners, shallow stack, pops down to the origin.
    corner_set[0] = 32'hFFFF_FFFF;
    corner_set[1] = 32'h0000_0000;
    corner_set[2] = 32'h3200_0A00;
    corner_set[3] = 32'h1234_5678;
    corner_set[4] = 32'h8000_0000;
    corner_set[5] = 32'h0080_0080;
    load_config(32'd3, 32'd2);
    send_item(1'b0, PopCode, 8'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd1, 8'd0, 8'd0);
    send_item(1'b1, PopCode, 8'd255, 8'd255);
    send_item(1'b0, PopCode, 8'd0, 8'd0);
    send_item(1'b0, PopCode, 8'd0, 8'd0);
    send_item(1'b0, PopCode, 8'd0, 8'd0);
    send_item(1'b0, 8'd2, 8'd0, 8'd0);
    send_item(1'b0, 8'd3, 8'd0, 8'd0);
    send_item(1'b0, 8'd254, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd255, 8'd255);
    drain_results();

    // Corner count above the corner limit, no pushes at all.
    load_config(32'd7, 32'd0);
    send_item(1'b0, 8'd5, 8'd0, 8'd0);
    send_item(1'b0, 8'd6, 8'd0, 8'd0);
    send_item(1'b0, 8'd5, 8'd0, 8'd0);
    send_item(1'b0, PopCode, 8'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    drain_results();

    // Zero corners: every step is unknown.
    load_config(32'd0, 32'd31);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, PopCode, 8'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd255, 8'd0);
    drain_results();

    // Random phases: new settings, new idle pattern, mostly valid steps.
    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0:       begin send_gap_pct <= 0;  out_stall_pct <= 0;  end
        1:       begin send_gap_pct <= 47; out_stall_pct <= 0;  end
        2:       begin send_gap_pct <= 0;  out_stall_pct <= 47; end
        default: begin send_gap_pct <= 20; out_stall_pct <= 20; end
      endcase
      span = (p % 3 == 0) ? 24 : (p % 3 == 1) ? 300 : 512;
      for (int i = 0; i < MaxCornersDefault; i++) begin
        if ($urandom_range(7) == 0) corner_set[i] = $urandom;
        else corner_set[i] = {16'($urandom_range(span * 128 - 1)),
                              16'($urandom_range(span * 128 - 1))};
      end
      n_sel     = (p == 4) ? 7 : (p == 5) ? 1 : (p == 6) ? 6 : (p == 7) ? 0
                                                            : $urandom_range(2, 6);
      depth_sel = (p == 1) ? 31 : (p == 2) ? 0 : (p == 3) ? 1 : $urandom_range(31);
      pop_pct   = (p == 1) ? 5 : $urandom_range(5, 35);
      n_use     = (n_sel == 0) ? 1 : (n_sel > MaxCornersDefault) ? MaxCornersDefault : n_sel;
      reach     = (span > 256) ? 256 : span;
      // Upper bits of the narrow registers are junk the block must drop.
      rnd_word = $urandom;
      load_config({rnd_word[31:CornerCntW], n_sel[CornerCntW-1:0]},
                  {rnd_word[31:MaxDepthW] ^ 27'h5A5A5A5, depth_sel[MaxDepthW-1:0]});
      for (int i = 0; i < ItemsPerPhase; i++) begin
        pick = $urandom_range(99);
        if (pick < NoisePct)
          send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < NoisePct + ReadPct) begin
          if ($urandom_range(4) == 0)
            send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
          else
            send_item(1'b1, 8'($urandom), 8'($urandom_range(reach - 1)),
                      8'($urandom_range(reach - 1)));
        end else if (pick < NoisePct + ReadPct + pop_pct)
          send_item(1'b0, PopCode, 8'($urandom), 8'($urandom));
        else
          send_item(1'b0, 8'($urandom_range(n_use - 1)), 8'($urandom), 8'($urandom));
      end
      drain_results();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
